/* hdl/bcodec_pkg.sv */
// Shared types, constants and alphabet functions for the base64/base32 codec.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bcodec_pkg;

    localparam int ACC_W  = 13;
    localparam int PEND_W = 4;
    localparam int GRP_W  = 3;

    localparam logic [1:0] CFG_DECODE_MODE = 2'd0;
    localparam logic [1:0] CFG_ALPHABET    = 2'd1;
    localparam logic [1:0] CFG_WRAP        = 2'd2;
    localparam logic [1:0] CFG_SKIP        = 2'd3;

    localparam logic [15:0] WRAP_RESET = 16'd76;

    localparam logic [7:0] CHAR_EQ = 8'h3D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENC_CHAR,
        ST_ENC_NL,
        ST_ENC_FLUSH,
        ST_ENC_PAD,
        ST_ENC_PAD_NL,
        ST_CLEAR,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ENC_LOAD,
        OP_ENC_CHAR,
        OP_ENC_FLUSH,
        OP_PAD,
        OP_NEWLINE,
        OP_DEC,
        OP_CLEAR,
        OP_FINISH
    } op_t;

    typedef struct packed {
        logic accept;
        op_t  op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic decode_mode;
        logic end_flag;
        logic pend_ge_bits;
        logic pend_nonzero;
        logic group_nonzero;
        logic col_nonzero;
        logic wrap_next;
        logic slot_full;
        logic out_free;
    } dp_status_t;

    // 6-bit (or 5-bit when b32) value to alphabet character
    function automatic logic [7:0] char_of(input logic [5:0] v, input logic b32);
        logic [7:0] r;
        logic [7:0] v8;
        v8 = {2'b00, v};
        if (b32)
        begin
            v8 = {3'b000, v[4:0]};
            if (v8 < 8'd26)
                r = 8'h41 + v8;
            else
                r = 8'h32 + v8 - 8'd26;
        end
        else if (v8 < 8'd26)
            r = 8'h41 + v8;
        else if (v8 < 8'd52)
            r = 8'h61 + v8 - 8'd26;
        else if (v8 < 8'd62)
            r = 8'h30 + v8 - 8'd52;
        else if (v8 == 8'd62)
            r = 8'h2B;
        else
            r = 8'h2F;
        return r;
    endfunction

    // character to {valid, value}
    function automatic logic [6:0] char_value(input logic [7:0] c, input logic b32);
        logic [6:0] r;
        logic [7:0] d;
        r = 7'd0;
        d = 8'd0;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            d = c - 8'h41;
            r = {1'b1, d[5:0]};
        end
        else if (b32)
        begin
            if (c >= 8'h32 && c <= 8'h37)
            begin
                d = c - 8'h32 + 8'd26;
                r = {1'b1, d[5:0]};
            end
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            d = c - 8'h61 + 8'd26;
            r = {1'b1, d[5:0]};
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c - 8'h30 + 8'd52;
            r = {1'b1, d[5:0]};
        end
        else if (c == 8'h2B)
            r = {1'b1, 6'd62};
        else if (c == 8'h2F)
            r = {1'b1, 6'd63};
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/bcodec_ctrl.sv */
// Sequencing state machine of the codec: steps one input word through its results.
// Depends on bcodec_pkg; drives commands to bcodec_dp and reads its status.
`timescale 1ns / 1ps
`default_nettype none

module bcodec_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   byte_present,
    input  wire logic                   end_of_stream,
    input  wire bcodec_pkg::dp_status_t status,
    output bcodec_pkg::ctrl_cmd_t       cmd
);

    bcodec_pkg::state_t state_reg;
    bcodec_pkg::state_t state_next;
    logic               stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bcodec_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.accept = 1'b0;
        cmd.op     = bcodec_pkg::OP_NONE;
        in_ready   = 1'b0;
        // a new result needs the held one to move on to the output register
        stall      = status.slot_full && !status.out_free;
        case (state_reg)
            bcodec_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.decode_mode)
                    begin
                        if (byte_present)
                            cmd.op = bcodec_pkg::OP_DEC;
                        state_next = end_of_stream ? bcodec_pkg::ST_CLEAR
                                                   : bcodec_pkg::ST_FINISH;
                    end
                    else if (byte_present)
                    begin
                        cmd.op     = bcodec_pkg::OP_ENC_LOAD;
                        state_next = bcodec_pkg::ST_ENC_CHAR;
                    end
                    else if (end_of_stream)
                        state_next = bcodec_pkg::ST_ENC_FLUSH;
                    else
                        state_next = bcodec_pkg::ST_FINISH;
                end
            end
            bcodec_pkg::ST_ENC_CHAR:
            begin
                if (status.pend_ge_bits)
                begin
                    if (!stall)
                    begin
                        cmd.op     = bcodec_pkg::OP_ENC_CHAR;
                        state_next = status.wrap_next ? bcodec_pkg::ST_ENC_NL
                                                      : bcodec_pkg::ST_ENC_CHAR;
                    end
                end
                else
                    state_next = status.end_flag ? bcodec_pkg::ST_ENC_FLUSH
                                                 : bcodec_pkg::ST_FINISH;
            end
            bcodec_pkg::ST_ENC_NL:
            begin
                if (!stall)
                begin
                    cmd.op     = bcodec_pkg::OP_NEWLINE;
                    state_next = bcodec_pkg::ST_ENC_CHAR;
                end
            end
            bcodec_pkg::ST_ENC_FLUSH:
            begin
                if (status.pend_nonzero)
                begin
                    if (!stall)
                    begin
                        cmd.op     = bcodec_pkg::OP_ENC_FLUSH;
                        state_next = status.wrap_next ? bcodec_pkg::ST_ENC_PAD_NL
                                                      : bcodec_pkg::ST_ENC_PAD;
                    end
                end
                else
                    state_next = bcodec_pkg::ST_ENC_PAD;
            end
            bcodec_pkg::ST_ENC_PAD_NL:
            begin
                if (!stall)
                begin
                    cmd.op     = bcodec_pkg::OP_NEWLINE;
                    state_next = bcodec_pkg::ST_ENC_PAD;
                end
            end
            bcodec_pkg::ST_ENC_PAD:
            begin
                if (status.group_nonzero)
                begin
                    if (!stall)
                    begin
                        cmd.op     = bcodec_pkg::OP_PAD;
                        state_next = status.wrap_next ? bcodec_pkg::ST_ENC_PAD_NL
                                                      : bcodec_pkg::ST_ENC_PAD;
                    end
                end
                else if (status.col_nonzero)
                begin
                    // close the partial last line
                    if (!stall)
                    begin
                        cmd.op     = bcodec_pkg::OP_NEWLINE;
                        state_next = bcodec_pkg::ST_CLEAR;
                    end
                end
                else
                    state_next = bcodec_pkg::ST_CLEAR;
            end
            bcodec_pkg::ST_CLEAR:
            begin
                cmd.op     = bcodec_pkg::OP_CLEAR;
                state_next = bcodec_pkg::ST_FINISH;
            end
            bcodec_pkg::ST_FINISH:
            begin
                if (status.slot_full)
                begin
                    if (status.out_free)
                    begin
                        cmd.op     = bcodec_pkg::OP_FINISH;
                        state_next = bcodec_pkg::ST_IDLE;
                    end
                end
                else
                    state_next = bcodec_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bcodec_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/bcodec_dp.sv */
// Datapath of the codec: configuration, bit accumulator, counters, held result
// and output register. Depends on bcodec_pkg; driven by bcodec_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module bcodec_dp #(
    parameter int COLUMN_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [15:0]            cfg_data,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   end_of_stream,
    input  wire bcodec_pkg::ctrl_cmd_t  cmd,
    output bcodec_pkg::dp_status_t      status,
    input  wire logic                   out_ready,
    output logic                        out_valid,
    output logic [7:0]                  out_byte,
    output logic                        result_kind,
    output logic                        last_of_run
);

    localparam int CMP_W = (COLUMN_BITS > 16) ? COLUMN_BITS : 16;

    // configuration
    logic        decode_reg,   decode_next;
    logic        alpha_reg,    alpha_next;
    logic [15:0] wrap_reg,     wrap_next;
    logic        skip_reg,     skip_next;

    // stream state
    logic [bcodec_pkg::ACC_W-1:0]  acc_reg,  acc_next;
    logic [bcodec_pkg::PEND_W-1:0] pend_reg, pend_next;
    logic [bcodec_pkg::GRP_W-1:0]  grp_reg,  grp_next;
    logic [COLUMN_BITS-1:0]        col_reg,  col_next;
    logic                          err_reg,  err_next;
    logic                          end_reg,  end_next;

    // held result and output register
    logic       slot_full_reg, slot_full_next;
    logic [7:0] slot_byte_reg, slot_byte_next;
    logic       slot_kind_reg, slot_kind_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg,  out_byte_next;
    logic       out_kind_reg,  out_kind_next;
    logic       out_last_reg,  out_last_next;

    logic [bcodec_pkg::PEND_W-1:0]  bits_w;
    logic [bcodec_pkg::PEND_W-1:0]  pend_clamp;
    logic [bcodec_pkg::PEND_W-1:0]  pend_sub;
    logic [bcodec_pkg::PEND_W-1:0]  pend_dec;
    logic [bcodec_pkg::PEND_W-1:0]  flush_sh;
    logic [bcodec_pkg::ACC_W-1:0]   enc_shift;
    logic [bcodec_pkg::ACC_W+5:0]   flush_wide;
    logic [bcodec_pkg::ACC_W-1:0]   acc_dec;
    logic [bcodec_pkg::ACC_W-1:0]   dec_shift;
    logic [6:0]                     dec_val;
    logic [bcodec_pkg::GRP_W-1:0]   grp_mask;
    logic [COLUMN_BITS-1:0]         col_inc;
    logic                           wrap_hit;
    logic                           emit;
    logic [7:0]                     emit_byte;
    logic                           emit_kind;
    logic                           out_free;
    logic                           skip_char;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_reg    <= 1'b0;
            alpha_reg     <= 1'b0;
            wrap_reg      <= bcodec_pkg::WRAP_RESET;
            skip_reg      <= 1'b0;
            acc_reg       <= '0;
            pend_reg      <= '0;
            grp_reg       <= '0;
            col_reg       <= '0;
            err_reg       <= 1'b0;
            end_reg       <= 1'b0;
            slot_full_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            decode_reg    <= decode_next;
            alpha_reg     <= alpha_next;
            wrap_reg      <= wrap_next;
            skip_reg      <= skip_next;
            acc_reg       <= acc_next;
            pend_reg      <= pend_next;
            grp_reg       <= grp_next;
            col_reg       <= col_next;
            err_reg       <= err_next;
            end_reg       <= end_next;
            slot_full_reg <= slot_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_byte_reg <= slot_byte_next;
        slot_kind_reg <= slot_kind_next;
        out_byte_reg  <= out_byte_next;
        out_kind_reg  <= out_kind_next;
        out_last_reg  <= out_last_next;
    end

    always_comb
    begin
        bits_w     = alpha_reg ? 4'd5 : 4'd6;
        grp_mask   = alpha_reg ? 3'd7 : 3'd3;
        pend_clamp = (pend_reg > bits_w - 4'd1) ? bits_w - 4'd1 : pend_reg;
        pend_sub   = pend_reg - bits_w;
        enc_shift  = acc_reg >> pend_sub;
        flush_sh   = bits_w - pend_clamp;
        flush_wide = {6'd0, acc_reg} << flush_sh;
        col_inc    = col_reg + COLUMN_BITS'(1);
        wrap_hit   = (wrap_reg != 16'd0) && (CMP_W'(col_inc) == CMP_W'(wrap_reg));
        out_free   = !out_valid_reg || out_ready;

        dec_val   = bcodec_pkg::char_value(data_byte, alpha_reg);
        acc_dec   = alpha_reg ? {acc_reg[7:0], dec_val[4:0]} : {acc_reg[6:0], dec_val[5:0]};
        pend_dec  = ((pend_reg > 4'd7) ? 4'd7 : pend_reg) + bits_w;
        dec_shift = acc_dec >> (pend_dec - 4'd8);
        skip_char = (data_byte == bcodec_pkg::CHAR_LF) || (data_byte == bcodec_pkg::CHAR_CR)
                    || (data_byte == bcodec_pkg::CHAR_EQ);

        status.decode_mode   = decode_reg;
        status.end_flag      = end_reg;
        status.pend_ge_bits  = pend_reg >= bits_w;
        status.pend_nonzero  = pend_clamp != 4'd0;
        status.group_nonzero = grp_reg != 3'd0;
        status.col_nonzero   = col_reg != '0;
        status.wrap_next     = wrap_hit;
        status.slot_full     = slot_full_reg;
        status.out_free      = out_free;

        decode_next = decode_reg;
        alpha_next  = alpha_reg;
        wrap_next   = wrap_reg;
        skip_next   = skip_reg;
        acc_next    = acc_reg;
        pend_next   = pend_reg;
        grp_next    = grp_reg;
        col_next    = col_reg;
        err_next    = err_reg;
        end_next    = cmd.accept ? end_of_stream : end_reg;

        emit      = 1'b0;
        emit_byte = 8'd0;
        emit_kind = 1'b0;

        slot_full_next = slot_full_reg;
        slot_byte_next = slot_byte_reg;
        slot_kind_next = slot_kind_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;

        case (cmd.op)
            bcodec_pkg::OP_ENC_LOAD:
            begin
                acc_next  = {acc_reg[4:0], data_byte};
                pend_next = pend_clamp + 4'd8;
            end
            bcodec_pkg::OP_ENC_CHAR:
            begin
                emit      = 1'b1;
                emit_byte = bcodec_pkg::char_of(enc_shift[5:0], alpha_reg);
                pend_next = pend_sub;
                grp_next  = (grp_reg + 3'd1) & grp_mask;
                col_next  = wrap_hit ? '0 : col_inc;
            end
            bcodec_pkg::OP_ENC_FLUSH:
            begin
                emit      = 1'b1;
                emit_byte = bcodec_pkg::char_of(flush_wide[5:0], alpha_reg);
                pend_next = '0;
                grp_next  = (grp_reg + 3'd1) & grp_mask;
                col_next  = wrap_hit ? '0 : col_inc;
            end
            bcodec_pkg::OP_PAD:
            begin
                emit      = 1'b1;
                emit_byte = bcodec_pkg::CHAR_EQ;
                grp_next  = (grp_reg + 3'd1) & grp_mask;
                col_next  = wrap_hit ? '0 : col_inc;
            end
            bcodec_pkg::OP_NEWLINE:
            begin
                emit      = 1'b1;
                emit_byte = bcodec_pkg::CHAR_LF;
            end
            bcodec_pkg::OP_DEC:
            begin
                if (!err_reg && !skip_char)
                begin
                    if (!dec_val[6])
                    begin
                        if (!skip_reg)
                        begin
                            emit      = 1'b1;
                            emit_kind = 1'b1;
                            err_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        acc_next  = acc_dec;
                        pend_next = pend_dec;
                        if (pend_dec >= 4'd8)
                        begin
                            pend_next = pend_dec - 4'd8;
                            emit      = 1'b1;
                            emit_byte = dec_shift[7:0];
                        end
                    end
                end
            end
            bcodec_pkg::OP_CLEAR:
            begin
                acc_next  = '0;
                pend_next = '0;
                grp_next  = '0;
                col_next  = '0;
                err_next  = 1'b0;
            end
            bcodec_pkg::OP_FINISH:
            begin
                // the held result is the last one of this word
                out_valid_next = 1'b1;
                out_byte_next  = slot_byte_reg;
                out_kind_next  = slot_kind_reg;
                out_last_next  = 1'b1;
                slot_full_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        if (emit)
        begin
            if (slot_full_reg)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = slot_byte_reg;
                out_kind_next  = slot_kind_reg;
                out_last_next  = 1'b0;
            end
            slot_full_next = 1'b1;
            slot_byte_next = emit_byte;
            slot_kind_next = emit_kind;
        end

        if (cfg_valid)
        begin
            case (cfg_index)
                bcodec_pkg::CFG_DECODE_MODE: decode_next = cfg_data[0];
                bcodec_pkg::CFG_ALPHABET:    alpha_next  = cfg_data[0];
                bcodec_pkg::CFG_WRAP:        wrap_next   = cfg_data;
                bcodec_pkg::CFG_SKIP:        skip_next   = cfg_data[0];
                default:                     skip_next   = skip_reg;
            endcase
            // drop the message in progress on a mode or alphabet change
            if (cfg_index == bcodec_pkg::CFG_DECODE_MODE || cfg_index == bcodec_pkg::CFG_ALPHABET)
            begin
                acc_next  = '0;
                pend_next = '0;
                grp_next  = '0;
                col_next  = '0;
                err_next  = 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign result_kind = out_kind_reg;
    assign last_of_run = out_last_reg;

endmodule

`default_nettype wire

/* hdl/base64_base32_stream_codec.sv */
// Streaming base64/base32 encoder and decoder, top level.
// Each result of a word waits in a one-deep slot before it moves to the output register.
// Without output stalls a word takes one cycle a result plus accept, sequencing and finish
// steps; a new word is taken only once the last one is finished; one result is held back to mark the last.
// Reset (rst_n, asynchronous, active low) clears all stream state; configuration returns
// to encode, base64, 76 columns, no skipping. Depends on bcodec_pkg, bcodec_ctrl, bcodec_dp.
`timescale 1ns / 1ps
`default_nettype none

module base64_base32_stream_codec #(
    parameter int COLUMN_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        end_of_stream,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             result_kind,
    output logic             last_of_run
);

    bcodec_pkg::ctrl_cmd_t  cmd;
    bcodec_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    bcodec_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .byte_present  (byte_present),
        .end_of_stream (end_of_stream),
        .status        (status),
        .cmd           (cmd)
    );

    bcodec_dp #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .out_byte      (out_byte),
        .result_kind   (result_kind),
        .last_of_run   (last_of_run)
    );

endmodule

`default_nettype wire

/* hdl/bcodec_checker.sv */
// Port-level checks of the codec, attached to the top level by bind.
// Depends only on the ports of base64_base32_stream_codec.
`timescale 1ns / 1ps
`default_nettype none

module bcodec_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  out_byte,
    input wire logic        result_kind,
    input wire logic        last_of_run
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
                                    && $stable(result_kind) && $stable(last_of_run))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind |-> out_byte == 8'd0 && last_of_run)
        else $error("error result not zero or not last");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("new word taken while the previous one is in work");

    // only the closing result of a word can still wait once the block is idle
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_ready |-> last_of_run)
        else $error("unfinished run while idle");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind base64_base32_stream_codec bcodec_checker u_bcodec_checker (.*);

`default_nettype wire
